@@ design/assert_macros.svh @@
// assertion helpers, empty when synthesising
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define PCLS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pcls check failed");
// checked at every edge, reset included
`define PCLS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("pcls reset check failed");
`else
`define PCLS_ASSERT(lbl, prop)
`define PCLS_ASSERT_RST(lbl, prop)
`endif
`endif

@@ design/pcls_pkg.sv @@
package pcls_pkg;

  // configuration register indexes
  localparam int CFG_ADDR_BITS = 2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CONTACT_RADIUS  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ITERATION_COUNT = 2'd1;

  localparam int ITER_BITS = 8;
  localparam logic [ITER_BITS-1:0] ITER_RESET = 8'd100;

  // shared multiplier a-side width, holds a scaled magnitude below 2^30
  localparam int MUL_A_BITS = 31;

  // scaling window for the length and normalise passes
  localparam logic [63:0] SCALE_TOP = 64'd1 << 30;
  localparam logic [63:0] SCALE_LOW = 64'd1 << 29;

  // bit-pair square root
  localparam int SQRT_BITS  = 64;
  localparam int SQRT_STEPS = 32;
  localparam int LEN_BITS   = 32;
  localparam int REM_BITS   = 33;

endpackage

@@ design/plane_contact_length_solver.sv @@
// plane contact length solver, one item at a time through a shared multiplier
// the 32-step square root and the 3 x (U+1)-step divider run once per iteration on the
// single shared datapath; a new word is taken only once the last result is loaded out
// reset: synchronous rst_n clears the sequencer, output valid, radius (0) and iterations (100)
`include "assert_macros.svh"

module plane_contact_length_solver import pcls_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  // parent x,y,z, child x,y,z, plane x,y,z, normal x,y,z (lowest bits first)
  input  logic [((12*WORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // result x,y,z (lowest bits first)
  output logic [((3*WORD_BITS+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_wen,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [((WORD_BITS-1>8)?WORD_BITS-1:8)-1:0] cfg_wdata
);

  localparam int W    = WORD_BITS;
  localparam int U    = ((60 - W) > 28) ? 28 : (60 - W);      // unit vector fraction bits
  localparam int UB   = U + 2;                                 // signed unit component
  localparam int AW   = ((W + 1) > 30) ? (W + 1) : 30;          // magnitude lanes
  localparam int MB   = ((W + 4) > 31) ? (W + 4) : 31;          // multiplier b-side
  localparam int PRW  = MUL_A_BITS + MB;
  localparam int ACCW = ((U + W + 4) > 63) ? (U + W + 4) : 63;
  localparam int DW   = W + 3;                                 // recorded distance
  localparam int RW   = W - 1;                                 // radius register
  localparam int OUTB = ((3*W+7)/8)*8;
  localparam int JW   = $clog2(U + 1);
  localparam int SW   = 5;

  localparam logic signed [PRW-1:0] WMAX = {{(PRW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PRW-1:0] WMIN = ~WMAX;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SHIFT  = 4'd1;
  localparam logic [3:0] S_SQ_M   = 4'd2;
  localparam logic [3:0] S_SQ_A   = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DOT_M  = 4'd6;
  localparam logic [3:0] S_DOT_A  = 4'd7;
  localparam logic [3:0] S_CMP    = 4'd8;
  localparam logic [3:0] S_PUSH_M = 4'd9;
  localparam logic [3:0] S_PUSH_A = 4'd10;
  localparam logic [3:0] S_REST_M = 4'd11;
  localparam logic [3:0] S_REST_A = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // which vector pass is running
  localparam logic [1:0] PH_NORMAL  = 2'd0;
  localparam logic [1:0] PH_DIST    = 2'd1;
  localparam logic [1:0] PH_RESTORE = 2'd2;

  // source of the vector loaded into the magnitude lanes
  localparam logic [1:0] LD_NORM = 2'd0;
  localparam logic [1:0] LD_DIST = 2'd1;
  localparam logic [1:0] LD_REST = 2'd2;

  function automatic logic signed [W-1:0] sat_w(input logic signed [PRW-1:0] x);
    logic signed [PRW-1:0] y;
    y = x;
    if (x > WMAX) y = WMAX;
    if (x < WMIN) y = WMIN;
    return y[W-1:0];
  endfunction

  // configuration
  logic [RW-1:0]        contact_radius_r;
  logic [ITER_BITS-1:0] iteration_count_r;

  // control
  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       len_mode_r, len_mode_nxt;
  logic [1:0] k_r, k_nxt;
  logic [ITER_BITS-1:0] it_r, it_nxt;
  logic [SW-1:0] s_r, s_nxt;
  logic [5:0] sq_cnt_r, sq_cnt_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic out_valid_r, out_valid_nxt;

  // payload
  logic signed [W-1:0] p_r[3], pl_r[3], c_r[3], c_nxt[3];
  logic [AW-1:0] a_r[3], a_nxt[3];
  logic sg_r[3], sg_nxt[3];
  logic signed [UB-1:0] nu_r[3], nu_nxt[3], du_r[3], du_nxt[3];
  logic signed [ACCW-1:0] acc_r, acc_nxt;
  logic signed [MB-1:0] pen_r, pen_nxt;
  logic [DW-1:0] dist_r, dist_nxt;
  logic [SQRT_BITS-1:0] n_r, n_nxt, r_r, r_nxt, bit_r, bit_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic [REM_BITS-1:0] rem_r, rem_nxt;
  logic [U:0] q_r, q_nxt;
  logic [OUTB-1:0] out_data_r, out_data_nxt;

  // shared multiplier
  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MB-1:0]         mul_b;
  logic signed [PRW-1:0]        prod_r;

  // helpers
  logic vec_done, ld_go;
  logic [1:0] ld_src;
  logic signed [W:0] ld_v[3];
  logic [W:0] ld_m[3];
  logic any_big, all_low, all_zero;
  logic signed [W:0] dif;
  logic signed [ACCW-1:0] r_wide;
  logic [SQRT_BITS-1:0] sq_t, r_new;
  logic sq_ge;
  logic [REM_BITS-1:0] rem_sh;
  logic div_ge;
  logic [U:0] q_new;
  logic signed [UB-1:0] u_val;
  logic [DW+LEN_BITS-1:0] dist_wide;
  logic in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign r_wide     = $signed(ACCW'(contact_radius_r) << U);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contact_radius_r  <= '0;
      iteration_count_r <= ITER_RESET;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_CONTACT_RADIUS:  contact_radius_r  <= cfg_wdata[RW-1:0];
        REG_ITERATION_COUNT: iteration_count_r <= cfg_wdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // operand select for the one multiplier, product always registered
  always_comb begin
    dif   = (W+1)'(c_r[k_r]) - (W+1)'(pl_r[k_r]);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ_M: begin
        mul_a = MUL_A_BITS'(a_r[k_r][29:0]);
        mul_b = MB'(a_r[k_r][29:0]);
      end
      S_DOT_M: begin
        mul_a = MUL_A_BITS'(nu_r[k_r]);
        mul_b = MB'(dif);
      end
      S_PUSH_M: begin
        mul_a = MUL_A_BITS'(nu_r[k_r]);
        mul_b = pen_r;
      end
      S_REST_M: begin
        mul_a = MUL_A_BITS'(du_r[k_r]);
        mul_b = MB'(dist_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // lane tests for the scaling pass
  always_comb begin
    any_big  = 1'b0;
    all_low  = 1'b1;
    all_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, a_r[i]} >= (AW+1)'(SCALE_TOP)) any_big = 1'b1;
      if ({1'b0, a_r[i]} >= (AW+1)'(SCALE_LOW)) all_low = 1'b0;
      if (a_r[i] != '0) all_zero = 1'b0;
    end
  end

  // square root step and divider step
  always_comb begin
    sq_t   = r_r + bit_r;
    sq_ge  = (n_r >= sq_t);
    r_new  = sq_ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);
    rem_sh = {rem_r[REM_BITS-2:0], (j_r == JW'(U)) ? a_r[k_r][0] : 1'b0};
    div_ge = (rem_sh >= {1'b0, len_r});
    q_new  = {q_r[U-1:0], div_ge};
    u_val  = sg_r[k_r] ? -UB'(q_new) : UB'(q_new);
    dist_wide = {{DW{1'b0}}, r_new[LEN_BITS-1:0]} << s_r;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    len_mode_nxt  = len_mode_r;
    k_nxt         = k_r;
    it_nxt        = it_r;
    s_nxt         = s_r;
    sq_cnt_nxt    = sq_cnt_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    pen_nxt       = pen_r;
    dist_nxt      = dist_r;
    n_nxt         = n_r;
    r_nxt         = r_r;
    bit_nxt       = bit_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    for (int i = 0; i < 3; i++) begin
      c_nxt[i]  = c_r[i];
      a_nxt[i]  = a_r[i];
      sg_nxt[i] = sg_r[i];
      nu_nxt[i] = nu_r[i];
      du_nxt[i] = du_r[i];
    end
    vec_done = 1'b0;
    ld_go    = 1'b0;
    ld_src   = LD_NORM;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < 3; i++) c_nxt[i] = $signed(in_tdata[(3+i)*W +: W]);
          ld_go     = 1'b1;
          ld_src    = LD_NORM;
          phase_nxt = PH_NORMAL;
        end
      end
      S_SHIFT: begin
        if (any_big) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] >> 1;
          s_nxt = s_r + SW'(1);
        end else if (!len_mode_r && all_zero) begin
          // zero vector normalises to zero
          for (int i = 0; i < 3; i++) begin
            if (phase_r == PH_NORMAL) nu_nxt[i] = '0;
            else du_nxt[i] = '0;
          end
          vec_done = 1'b1;
        end else if (!len_mode_r && all_low) begin
          for (int i = 0; i < 3; i++) a_nxt[i] = a_r[i] << 1;
        end else begin
          k_nxt     = 2'd0;
          acc_nxt   = '0;
          state_nxt = S_SQ_M;
        end
      end
      S_SQ_M: state_nxt = S_SQ_A;
      S_SQ_A: begin
        acc_nxt = acc_r + ACCW'(prod_r);
        if (k_r == 2'd2) begin
          n_nxt      = SQRT_BITS'($unsigned(acc_nxt));
          r_nxt      = '0;
          bit_nxt    = SQRT_BITS'(1) << (SQRT_BITS - 2);
          sq_cnt_nxt = '0;
          state_nxt  = S_SQRT;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ_M;
        end
      end
      S_SQRT: begin
        if (sq_ge) n_nxt = n_r - sq_t;
        r_nxt      = r_new;
        bit_nxt    = bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'(SQRT_STEPS - 1)) begin
          len_nxt = r_new[LEN_BITS-1:0];
          if (len_mode_r) begin
            dist_nxt = dist_wide[DW-1:0];
            vec_done = 1'b1;
          end else begin
            k_nxt     = 2'd0;
            rem_nxt   = REM_BITS'(a_r[0][29:1]);
            q_nxt     = '0;
            j_nxt     = JW'(U);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = div_ge ? (rem_sh - {1'b0, len_r}) : rem_sh;
        q_nxt   = q_new;
        if (j_r == '0) begin
          if (phase_r == PH_NORMAL) nu_nxt[k_r] = u_val;
          else du_nxt[k_r] = u_val;
          if (k_r == 2'd2) begin
            vec_done = 1'b1;
          end else begin
            k_nxt   = k_r + 2'd1;
            rem_nxt = REM_BITS'(a_r[k_nxt][29:1]);
            q_nxt   = '0;
            j_nxt   = JW'(U);
          end
        end else begin
          j_nxt = j_r - JW'(1);
        end
      end
      S_DOT_M: state_nxt = S_DOT_A;
      S_DOT_A: begin
        acc_nxt = acc_r + ACCW'(prod_r);
        if (k_r == 2'd2) state_nxt = S_CMP;
        else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_DOT_M;
        end
      end
      S_CMP: begin
        if (acc_r < r_wide) begin
          pen_nxt   = MB'((acc_r - r_wide) >>> U);
          k_nxt     = 2'd0;
          state_nxt = S_PUSH_M;
        end else begin
          ld_go     = 1'b1;
          ld_src    = LD_REST;
          phase_nxt = PH_RESTORE;
        end
      end
      S_PUSH_M: state_nxt = S_PUSH_A;
      S_PUSH_A: begin
        c_nxt[k_r] = sat_w(PRW'(c_r[k_r]) - (prod_r >>> U));
        if (k_r == 2'd2) begin
          ld_go     = 1'b1;
          ld_src    = LD_REST;
          phase_nxt = PH_RESTORE;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_PUSH_M;
        end
      end
      S_REST_M: state_nxt = S_REST_A;
      S_REST_A: begin
        c_nxt[k_r] = sat_w(PRW'(p_r[k_r]) + (prod_r >>> U));
        if (k_r == 2'd2) begin
          it_nxt = it_r + ITER_BITS'(1);
          if (it_nxt == iteration_count_r) state_nxt = S_DONE;
          else begin
            k_nxt     = 2'd0;
            acc_nxt   = '0;
            state_nxt = S_DOT_M;
          end
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_REST_M;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = OUTB'({c_r[2], c_r[1], c_r[0]});
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // end of a length or normalise pass
    if (vec_done) begin
      case (phase_r)
        PH_NORMAL: begin
          ld_go     = 1'b1;
          ld_src    = LD_DIST;
          phase_nxt = PH_DIST;
        end
        PH_DIST: begin
          if (iteration_count_r == '0) state_nxt = S_DONE;
          else begin
            it_nxt    = '0;
            k_nxt     = 2'd0;
            acc_nxt   = '0;
            state_nxt = S_DOT_M;
          end
        end
        PH_RESTORE: begin
          k_nxt     = 2'd0;
          state_nxt = S_REST_M;
        end
        default: state_nxt = S_IDLE;
      endcase
    end

    // load a vector into the magnitude lanes
    for (int i = 0; i < 3; i++) begin
      case (ld_src)
        LD_NORM: ld_v[i] = (W+1)'($signed(in_tdata[(9+i)*W +: W]));
        LD_DIST: ld_v[i] = (W+1)'(p_r[i]) - (W+1)'(c_r[i]);
        LD_REST: ld_v[i] = (W+1)'(c_nxt[i]) - (W+1)'(p_r[i]);
        default: ld_v[i] = '0;
      endcase
      ld_m[i] = ld_v[i][W] ? $unsigned(-ld_v[i]) : $unsigned(ld_v[i]);
    end
    if (ld_go) begin
      for (int i = 0; i < 3; i++) begin
        a_nxt[i]  = AW'(ld_m[i]);
        sg_nxt[i] = ld_v[i][W];
      end
      s_nxt        = '0;
      len_mode_nxt = (ld_src == LD_DIST);
      state_nxt    = S_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        p_r[i]  <= $signed(in_tdata[i*W +: W]);
        pl_r[i] <= $signed(in_tdata[(6+i)*W +: W]);
      end
    end
    phase_r    <= phase_nxt;
    len_mode_r <= len_mode_nxt;
    k_r        <= k_nxt;
    it_r       <= it_nxt;
    s_r        <= s_nxt;
    sq_cnt_r   <= sq_cnt_nxt;
    j_r        <= j_nxt;
    acc_r      <= acc_nxt;
    pen_r      <= pen_nxt;
    dist_r     <= dist_nxt;
    n_r        <= n_nxt;
    r_r        <= r_nxt;
    bit_r      <= bit_nxt;
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 3; i++) begin
      c_r[i]  <= c_nxt[i];
      a_r[i]  <= a_nxt[i];
      sg_r[i] <= sg_nxt[i];
      nu_r[i] <= nu_nxt[i];
      du_r[i] <= du_nxt[i];
    end
  end

  `PCLS_ASSERT(a_busy_after_accept, in_acc |=> (state_r != S_IDLE))
  `PCLS_ASSERT(a_div_len_nonzero, (state_r == S_DIV) |-> (len_r != '0))
  `PCLS_ASSERT(a_iter_below_count, (state_r == S_DOT_M) |-> (it_r < iteration_count_r))
  `PCLS_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_tvalid)

endmodule

@@ tb/tb_top.sv @@
module tb_top import pcls_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int UNIT_FRAC = 28;  // fraction bits of unit vectors for 32-bit words
  localparam int IDLE_LIMIT = 300000;  // watchdog limit, set above the longest item at 255 iterations

  // solved child point predictor plus the queue of points still to come out
  class contact_scoreboard;
    bit [30:0] radius;
    bit [7:0] iters;
    int errors;
    bit [95:0] solved_q[$];

    function new();
      radius = '0;
      iters = ITER_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_BITS-1:0] addr, bit [30:0] value);
      if (addr == REG_CONTACT_RADIUS) begin
        radius = value;
      end else if (addr == REG_ITERATION_COUNT) begin
        iters = value[7:0];
      end
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function longint unsigned mag(longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function longint clamp(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function longint unsigned length_of(input longint v[3]);
      longint unsigned a[3], m, sum;
      int s;
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) a[i] = mag(v[i]);
      m = (a[0] > a[1]) ? a[0] : a[1];
      if (a[2] > m) m = a[2];
      while ((m >> s) >= SCALE_TOP) s++;
      for (int i = 0; i < 3; i++) sum += (a[i] >> s) * (a[i] >> s);
      return isqrt(sum) << s;
    endfunction

    function void unit_vec(input longint v[3], output longint u[3]);
      longint unsigned a[3], b[3], m, sum, len, q;
      int dn, up;
      sum = 0;
      dn = 0;
      up = 0;
      for (int i = 0; i < 3; i++) a[i] = mag(v[i]);
      m = (a[0] > a[1]) ? a[0] : a[1];
      if (a[2] > m) m = a[2];
      if (m == 0) begin
        for (int i = 0; i < 3; i++) u[i] = 0;
        return;
      end
      while ((m >> dn) >= SCALE_TOP) dn++;
      while (((m >> dn) << up) < SCALE_LOW) up++;
      for (int i = 0; i < 3; i++) begin
        b[i] = (a[i] >> dn) << up;
        sum += b[i] * b[i];
      end
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
        q = (b[i] << UNIT_FRAC) / len;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    endfunction

    function void note_input(bit [383:0] word);
      longint p[3], c[3], pl[3], nv[3], nu[3], d[3], du[3];
      longint rw, rec_len, dot, pen;
      bit [95:0] res;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'($signed(word[W*i +: W]));
        c[i] = longint'($signed(word[W*(3+i) +: W]));
        pl[i] = longint'($signed(word[W*(6+i) +: W]));
        nv[i] = longint'($signed(word[W*(9+i) +: W]));
      end
      unit_vec(nv, nu);
      for (int i = 0; i < 3; i++) d[i] = p[i] - c[i];
      rec_len = longint'(length_of(d));
      rw = longint'(radius) << UNIT_FRAC;
      for (int it = 0; it < int'(iters); it++) begin
        dot = 0;
        for (int i = 0; i < 3; i++) dot += nu[i] * (c[i] - pl[i]);
        // push out along the normal by the shortfall
        if (dot < rw) begin
          pen = (dot - rw) >>> UNIT_FRAC;
          for (int i = 0; i < 3; i++) c[i] = clamp(c[i] - ((nu[i] * pen) >>> UNIT_FRAC));
        end
        // back onto the ray from the parent at the recorded distance
        for (int i = 0; i < 3; i++) d[i] = c[i] - p[i];
        unit_vec(d, du);
        for (int i = 0; i < 3; i++) c[i] = clamp(p[i] + ((du[i] * rec_len) >>> UNIT_FRAC));
      end
      for (int i = 0; i < 3; i++) res[W*i +: W] = c[i][W-1:0];
      solved_q.push_back(res);
    endfunction

    function void check_result(bit [95:0] got);
      bit [95:0] want;
      if (solved_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      want = solved_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got[W*i +: W] != want[W*i +: W]) begin
          $display("%0t: result field %0d expected %h actual %h", $realtime, i,
                   want[W*i +: W], got[W*i +: W]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic [383:0] in_tdata;  // parent x,y,z, child x,y,z, plane x,y,z, normal x,y,z
  logic in_tvalid;
  logic in_tready;
  logic [95:0] out_tdata;  // result x,y,z
  logic out_tvalid;
  logic out_tready;
  logic cfg_wen;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [30:0] cfg_wdata;

  contact_scoreboard sb;
  int burst_left;
  int stall_pct;
  int idle_cycles;

  plane_contact_length_solver #(.WORD_BITS(W)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stalls on its own pattern, intensity set per phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result checking and the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one word into the block, with bursts and random gaps in front
  task automatic send_word(bit [383:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    sb.note_input(word);
    burst_left--;
  endtask

  // registers change only once the block has drained
  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, bit [30:0] value);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.solved_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.write_reg(addr, value);
  endtask

  function automatic bit [383:0] pack_item(bit [31:0] f[12]);
    bit [383:0] w;
    for (int i = 0; i < 12; i++) w[W*i +: W] = f[i];
    return w;
  endfunction

  // coordinate: mostly moderate so pushes and restores stay in range, some full range
  function automatic bit [31:0] rand_coord();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    if (k < 8) return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    return $urandom();
  endfunction

  task automatic send_random(int count);
    bit [31:0] f[12];
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 12; i++) f[i] = rand_coord();
      case ($urandom_range(0, 9))
        0: f[9] = '0;                           // normal x zeroed only
        1: begin f[9] = '0; f[10] = '0; f[11] = '0; end
        2: begin f[3] = f[0]; f[4] = f[1]; f[5] = f[2]; end  // child on parent
        3: for (int i = 0; i < 12; i++) f[i] = $urandom();
        default: ;
      endcase
      send_word(pack_item(f));
    end
  endtask

  task automatic send_directed();
    bit [31:0] f[12];
    // all zero
    for (int i = 0; i < 12; i++) f[i] = '0;
    send_word(pack_item(f));
    // every field at the top, then at the bottom
    for (int i = 0; i < 12; i++) f[i] = 32'h7fff_ffff;
    send_word(pack_item(f));
    for (int i = 0; i < 12; i++) f[i] = 32'h8000_0000;
    send_word(pack_item(f));
    // parent and child at opposite corners, normal at the negative limit
    for (int i = 0; i < 3; i++) begin
      f[i] = 32'h7fff_ffff; f[3+i] = 32'h8000_0000; f[6+i] = '0; f[9+i] = 32'h8000_0000;
    end
    send_word(pack_item(f));
    // child below a floor, unit normal up
    for (int i = 0; i < 12; i++) f[i] = '0;
    f[1] = 32'h0005_0000; f[3] = 32'h0001_0000; f[4] = 32'hfffe_0000; f[10] = 32'h0001_0000;
    send_word(pack_item(f));
    // zero normal never pushes
    f[10] = '0;
    send_word(pack_item(f));
    // child on the parent
    f[3] = f[0]; f[4] = f[1]; f[5] = f[2]; f[10] = 32'h0000_0001;
    send_word(pack_item(f));
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_addr = REG_CONTACT_RADIUS;
    cfg_wdata = '0;
    burst_left = 0;
    stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: radius 0, 100 iterations
    send_directed();

    // top iteration count, widest radius, heavy stalls
    stall_pct = 70;
    write_reg(REG_ITERATION_COUNT, 31'h7fff_ffff);  // upper bits ignored, 255 left
    write_reg(REG_CONTACT_RADIUS, 31'h7fff_ffff);
    send_random(3);

    // zero iterations returns the starting child
    write_reg(REG_ITERATION_COUNT, 31'd0);
    send_directed();

    // writes past the last register do nothing
    write_reg(2'd2, 31'd7);
    write_reg(2'd3, 31'h1234_5678);
    stall_pct = 0;
    write_reg(REG_ITERATION_COUNT, 31'd1);
    send_random(20);

    // random phases with small iteration counts
    for (int ph = 0; ph < 6; ph++) begin
      stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 80);
      write_reg(REG_ITERATION_COUNT, 31'($urandom_range(1, 6)));
      case (ph % 3)
        0: write_reg(REG_CONTACT_RADIUS, 31'($urandom_range(0, 32'h0008_0000)));
        1: write_reg(REG_CONTACT_RADIUS, 31'($urandom()));
        default: write_reg(REG_CONTACT_RADIUS, '0);
      endcase
      send_random(40);
    end

    in_tvalid <= 1'b0;
    while (sb.solved_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
